// ----- src/slpp_pkg.sv -----
`timescale 1ns / 1ps
package slpp_pkg;

  // Function codes
  localparam logic [1:0] FUNC_RESTART = 2'd0;
  localparam logic [1:0] FUNC_SET     = 2'd1;
  localparam logic [1:0] FUNC_REFRESH = 2'd2;

  // Pattern codes
  localparam logic [2:0] PAT_BOOT    = 3'd0;
  localparam logic [2:0] PAT_TESTING = 3'd1;
  localparam logic [2:0] PAT_PASS    = 3'd2;
  localparam logic [2:0] PAT_FAIL    = 3'd3;
  localparam logic [2:0] PAT_HALT    = 3'd4;
  localparam logic [2:0] PAT_IDLE    = 3'd5;

  // Register map
  localparam logic REG_REFRESH_INTERVAL = 1'b0;
  localparam logic [7:0] INTERVAL_RESET = 8'd16;

  // Pattern timing, ms
  localparam int PHASE_W = 13;  // remainder estimate stays below twice the longest period
  localparam int RECIP_W = 23;

  localparam logic [PHASE_W-1:0] PASS_PERIOD = 13'd1000;
  localparam logic [PHASE_W-1:0] PASS_ON     = 13'd500;
  localparam logic [PHASE_W-1:0] FAIL_PERIOD = 13'd1400;
  localparam logic [PHASE_W-1:0] FAIL_SLOT   = 13'd100;
  localparam int                 FAIL_SLOTS  = 5;
  localparam logic [31:0]        HALT_SOLID  = 32'd5000;
  localparam logic [PHASE_W-1:0] HALT_PERIOD = 13'd2800;
  localparam logic [PHASE_W-1:0] HALT_SLOT   = 13'd80;
  localparam int                 HALT_SLOTS  = 9;
  localparam logic [PHASE_W-1:0] IDLE_PERIOD = 13'd2000;
  localparam logic [PHASE_W-1:0] IDLE_ON     = 13'd200;

  // floor(2^32 / period): quotient estimate is exact or one low
  localparam longint unsigned TWO_32 = 64'h1_0000_0000;
  localparam logic [RECIP_W-1:0] RECIP_PASS = RECIP_W'(TWO_32 / 1000);
  localparam logic [RECIP_W-1:0] RECIP_FAIL = RECIP_W'(TWO_32 / 1400);
  localparam logic [RECIP_W-1:0] RECIP_HALT = RECIP_W'(TWO_32 / 2800);
  localparam logic [RECIP_W-1:0] RECIP_IDLE = RECIP_W'(TWO_32 / 2000);

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [2:0]  pattern_code;
  } slpp_cmd_t;

  typedef struct packed {
    logic       led_on;
    logic       led_updated;
    logic [2:0] current_pattern;
  } slpp_res_t;

  // After the timing-state update
  typedef struct packed {
    logic        restart;
    logic        refresh;
    logic        early;
    logic [2:0]  pattern;
    logic [31:0] phase;
  } slpp_s1_t;

  // After the reciprocal multiply
  typedef struct packed {
    logic               restart;
    logic               refresh;
    logic               early;
    logic [2:0]         pattern;
    logic [RECIP_W-1:0] quot;
    logic [PHASE_W-1:0] phase_lo;
  } slpp_s2_t;

  function automatic logic [PHASE_W-1:0] period_of(input logic [2:0] pat);
    logic [PHASE_W-1:0] p;
    case (pat)
      PAT_FAIL: p = FAIL_PERIOD;
      PAT_HALT: p = HALT_PERIOD;
      PAT_IDLE: p = IDLE_PERIOD;
      default:  p = PASS_PERIOD;
    endcase
    return p;
  endfunction

  function automatic logic [RECIP_W-1:0] recip_of(input logic [2:0] pat);
    logic [RECIP_W-1:0] r;
    case (pat)
      PAT_FAIL: r = RECIP_FAIL;
      PAT_HALT: r = RECIP_HALT;
      PAT_IDLE: r = RECIP_IDLE;
      default:  r = RECIP_PASS;
    endcase
    return r;
  endfunction

endpackage

// ----- src/slpp_ctrl.sv -----
`timescale 1ns / 1ps
module slpp_ctrl
  import slpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  slpp_cmd_t   cmd,
  input  logic [7:0]  refresh_interval_ms,
  output logic        s1_valid,
  input  logic        s1_ready,
  output slpp_s1_t    s1
);

  logic [2:0]  active_pattern;
  logic [31:0] pattern_start_ms;
  logic [31:0] last_refresh_ms;

  logic        accept;
  logic [31:0] elapsed;
  logic [31:0] since_refresh;
  logic        refresh_ok;
  logic [2:0]  pattern_next;

  assign cmd_ready     = !s1_valid || s1_ready;
  assign accept        = cmd_valid && cmd_ready;
  assign elapsed       = cmd.now_ms - pattern_start_ms;
  assign since_refresh = cmd.now_ms - last_refresh_ms;
  assign refresh_ok    = since_refresh >= {24'd0, refresh_interval_ms};

  // pattern in force once this item is done
  always_comb begin
    case (cmd.func)
      FUNC_RESTART: pattern_next = PAT_BOOT;
      FUNC_SET:     pattern_next = cmd.pattern_code;
      default:      pattern_next = active_pattern;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_pattern   <= PAT_BOOT;
      pattern_start_ms <= '0;
      last_refresh_ms  <= '0;
      s1_valid         <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid     <= 1'b1;
        s1.restart   <= cmd.func == FUNC_RESTART;
        s1.refresh   <= (cmd.func == FUNC_REFRESH) && refresh_ok;
        s1.early     <= elapsed < HALT_SOLID;
        s1.phase     <= (active_pattern == PAT_HALT) ? elapsed - HALT_SOLID : elapsed;
        s1.pattern   <= pattern_next;
        case (cmd.func)
          FUNC_RESTART: begin
            active_pattern   <= PAT_BOOT;
            pattern_start_ms <= cmd.now_ms;
            last_refresh_ms  <= cmd.now_ms;
          end
          FUNC_SET: begin
            if (cmd.pattern_code != active_pattern) begin
              active_pattern   <= cmd.pattern_code;
              pattern_start_ms <= cmd.now_ms;
            end
          end
          FUNC_REFRESH: begin
            if (refresh_ok) begin
              last_refresh_ms <= cmd.now_ms;
            end
          end
          default: begin
          end
        endcase
      end else if (s1_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/slpp_phase.sv -----
`timescale 1ns / 1ps
module slpp_phase
  import slpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s1_valid,
  output logic      s1_ready,
  input  slpp_s1_t  s1,
  output logic      s2_valid,
  input  logic      s2_ready,
  output slpp_s2_t  s2
);

  logic [32+RECIP_W-1:0] product;

  assign s1_ready = !s2_valid || s2_ready;
  // phase * floor(2^32/period), upper bits are the quotient estimate
  assign product  = s1.phase * recip_of(s1.pattern);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_valid && s1_ready) begin
      s2_valid    <= 1'b1;
      s2.restart  <= s1.restart;
      s2.refresh  <= s1.refresh;
      s2.early    <= s1.early;
      s2.pattern  <= s1.pattern;
      s2.quot     <= product[32+RECIP_W-1:32];
      s2.phase_lo <= s1.phase[PHASE_W-1:0];
    end else if (s2_ready) begin
      s2_valid <= 1'b0;
    end
  end

endmodule

// ----- src/slpp_render.sv -----
`timescale 1ns / 1ps
module slpp_render
  import slpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s2_valid,
  output logic      s2_ready,
  input  slpp_s2_t  s2,
  output logic      res_valid,
  input  logic      res_ready,
  output slpp_res_t res
);

  logic               led_level;
  logic               led_next;
  logic               pat_level;
  logic               fail_on;
  logic               halt_on;
  logic [PHASE_W-1:0] period;
  logic [PHASE_W-1:0] qm;
  logic [PHASE_W-1:0] rem_est;
  logic [PHASE_W-1:0] rem;

  assign s2_ready = !res_valid || res_ready;
  assign period   = period_of(s2.pattern);
  // only the low bits matter: the true remainder estimate is below 2^PHASE_W
  assign qm       = s2.quot[PHASE_W-1:0] * period;
  assign rem_est  = s2.phase_lo - qm;
  assign rem      = (rem_est >= period) ? rem_est - period : rem_est;

  always_comb begin
    fail_on = 1'b0;
    for (int k = 0; k < FAIL_SLOTS; k += 2) begin
      if (rem >= PHASE_W'(k * FAIL_SLOT) && rem < PHASE_W'((k + 1) * FAIL_SLOT)) begin
        fail_on = 1'b1;
      end
    end
    halt_on = 1'b0;
    for (int k = 0; k < HALT_SLOTS; k += 2) begin
      if (rem >= PHASE_W'(k * HALT_SLOT) && rem < PHASE_W'((k + 1) * HALT_SLOT)) begin
        halt_on = 1'b1;
      end
    end
    case (s2.pattern)
      PAT_BOOT:    pat_level = 1'b0;
      PAT_TESTING: pat_level = 1'b1;
      PAT_PASS:    pat_level = rem < PASS_ON;
      PAT_FAIL:    pat_level = fail_on;
      PAT_HALT:    pat_level = s2.early || halt_on;
      PAT_IDLE:    pat_level = rem < IDLE_ON;
      default:     pat_level = 1'b0;
    endcase
    if (s2.restart) begin
      led_next = 1'b0;
    end else if (s2.refresh) begin
      led_next = pat_level;
    end else begin
      led_next = led_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_level <= 1'b0;
      res_valid <= 1'b0;
    end else if (s2_valid && s2_ready) begin
      led_level           <= led_next;
      res_valid           <= 1'b1;
      res.led_on          <= led_next;
      res.led_updated     <= s2.restart || s2.refresh;
      res.current_pattern <= s2.pattern;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

endmodule

// ----- src/status_led_pattern_player.sv -----
`timescale 1ns / 1ps
// Channel | Dir | Handshake            | Payload
// cmd     | in  | cmd_valid/cmd_ready  | slpp_cmd_t: func, now_ms, pattern_code
// res     | out | res_valid/res_ready  | slpp_res_t: led_on, led_updated, current_pattern
// apb     | in  | psel/penable/pready  | pwrite, paddr, pwdata, prdata (interval at 0x0)
//
// One item per cycle while the result side does not stall; each result is registered
// in turn through the ctrl, phase and render stages after its item is taken.
// The rate is set by the timing-state update (32-bit subtracts from the stored pattern
// start and last refresh times, and the compares on their results).
// Synchronous active-high reset: boot pattern, LED off, times zero, interval 16 ms.
// Each stage holds its item while the stage after it is full, so a stalled result
// only blocks input once all three stages are occupied.
module status_led_pattern_player
  import slpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // command items
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  slpp_cmd_t   cmd,
  // result items
  output logic        res_valid,
  input  logic        res_ready,
  output slpp_res_t   res,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] refresh_interval_ms;
  logic       cfg_write;

  logic       s1_valid;
  logic       s1_ready;
  slpp_s1_t   s1;
  logic       s2_valid;
  logic       s2_ready;
  slpp_s2_t   s2;

  // APB: zero wait states, one word register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_REFRESH_INTERVAL) ? {24'd0, refresh_interval_ms} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_interval_ms <= INTERVAL_RESET;
    end else if (cfg_write && paddr[2] == REG_REFRESH_INTERVAL) begin
      refresh_interval_ms <= pwdata[7:0];
    end
  end

  // stage 1: pattern/start/refresh bookkeeping, elapsed time
  slpp_ctrl u_ctrl (
    .clk                 (clk),
    .rst                 (rst),
    .cmd_valid           (cmd_valid),
    .cmd_ready           (cmd_ready),
    .cmd                 (cmd),
    .refresh_interval_ms (refresh_interval_ms),
    .s1_valid            (s1_valid),
    .s1_ready            (s1_ready),
    .s1                  (s1)
  );

  // stage 2: reciprocal multiply for the period quotient
  slpp_phase u_phase (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2)
  );

  // stage 3: remainder, pattern decode, LED level and result register
  slpp_render u_render (
    .clk       (clk),
    .rst       (rst),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2        (s2),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
